[rtl/amap_pkg.sv]
// shared types, widths and latencies of the angular map direction-to-uv block
`timescale 1ns / 1ps

package amap_pkg;

    localparam int COMP_W    = 16;
    localparam int TEX_W     = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int S_W       = 15;
    localparam int R_W       = 17;
    localparam int DEN_W     = 15;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int DIV_STEPS    = R_W;
    localparam int DIV_LAT      = DIV_STEPS + 4;

    typedef struct packed {
        logic signed [COMP_W-1:0] dir_x;
        logic signed [COMP_W-1:0] dir_y;
        logic signed [COMP_W-1:0] dir_z;
    } dir_item_t;

    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } tex_item_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_TOL = 2'd0,
        CFG_SINE_EPS   = 2'd1
    } cfg_reg_e;

endpackage

[rtl/amap_cordic.sv]
// pipelined cordic vectoring stage giving acos(z)/pi in unsigned q1.16
`timescale 1ns / 1ps

module amap_cordic
    import amap_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [COMP_W-1:0] z,
    input  logic        [S_W-1:0]    s,
    output logic                     out_valid,
    output logic        [R_W-1:0]    r
);

    localparam int CW    = 26;
    localparam int ANG_W = 19;

    localparam logic signed [ANG_W-1:0] ATAN_LUT [CORDIC_STEPS] = '{
        19'sd16384, 19'sd9672, 19'sd5110, 19'sd2594, 19'sd1302, 19'sd652,
        19'sd326, 19'sd163, 19'sd81, 19'sd41, 19'sd20, 19'sd10,
        19'sd5, 19'sd3, 19'sd1, 19'sd1
    };

    logic                    valid_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0]    x_reg     [0:CORDIC_STEPS];
    logic signed [CW-1:0]    y_reg     [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] a_reg     [0:CORDIC_STEPS];
    logic                    r_valid_reg;
    logic        [R_W-1:0]   r_reg;

    logic signed [CW-1:0] z_scaled;
    logic signed [CW-1:0] s_scaled;

    assign z_scaled = CW'($signed(z)) <<< 8;
    assign s_scaled = $signed({{(CW-S_W-8){1'b0}}, s, 8'b0});

    // entry: left half plane gets a quarter turn first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (z < 0)
        begin
            x_reg[0] <= s_scaled;
            y_reg[0] <= -z_scaled;
            a_reg[0] <= ANG_W'(32768);
        end
        else
        begin
            x_reg[0] <= z_scaled;
            y_reg[0] <= s_scaled;
            a_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (y_reg[i] > 0)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                a_reg[i+1] <= a_reg[i] + ATAN_LUT[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                a_reg[i+1] <= a_reg[i] - ATAN_LUT[i];
            end
        end
    end

    // clamp angle to [0, one]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else
        begin
            r_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_reg[CORDIC_STEPS] < 0)
        begin
            r_reg <= '0;
        end
        else if (a_reg[CORDIC_STEPS] > ANG_W'(65536))
        begin
            r_reg <= R_W'(65536);
        end
        else
        begin
            r_reg <= a_reg[CORDIC_STEPS][R_W-1:0];
        end
    end

    assign out_valid = r_valid_reg;
    assign r         = r_reg;

endmodule

[rtl/amap_div.sv]
// pipelined scale and rounded divide giving one map coordinate
`timescale 1ns / 1ps

module amap_div
    import amap_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [COMP_W-1:0] comp,
    input  logic        [R_W-1:0]    r,
    input  logic        [DEN_W-1:0]  den,
    output logic                     out_valid,
    output logic        [TEX_W-1:0]  coord
);

    localparam int NUM_W = COMP_W + R_W + 1;
    localparam int MAG_W = 32;
    localparam int DVD_W = MAG_W + 1;
    localparam int REM_W = DEN_W + 1;

    // multiply stage
    logic                    m_valid_reg;
    logic signed [NUM_W-1:0] m_num_reg;
    logic [DEN_W-1:0]        m_den_reg;

    // magnitude stage
    logic                    g_valid_reg;
    logic                    g_neg_reg;
    logic [MAG_W-1:0]        g_mag_reg;
    logic [DEN_W-1:0]        g_den_reg;

    // divide steps, stage 0 holds the rounded dividend split
    logic                    st_valid_reg [0:DIV_STEPS];
    logic                    st_neg_reg   [0:DIV_STEPS];
    logic                    st_ovf_reg   [0:DIV_STEPS];
    logic                    st_nz_reg    [0:DIV_STEPS];
    logic [DEN_W-1:0]        st_den_reg   [0:DIV_STEPS];
    logic [REM_W-1:0]        st_rem_reg   [0:DIV_STEPS];
    logic [R_W-1:0]          st_lo_reg    [0:DIV_STEPS];
    logic [R_W-1:0]          st_q_reg     [0:DIV_STEPS];

    logic                    o_valid_reg;
    logic [TEX_W-1:0]        o_coord_reg;

    logic signed [NUM_W-1:0] num_abs;
    logic [DVD_W-1:0]        dividend;
    logic [R_W-1:0]          q_final;
    logic [R_W+1:0]          biased;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg     <= 1'b0;
            g_valid_reg     <= 1'b0;
            st_valid_reg[0] <= 1'b0;
            o_valid_reg     <= 1'b0;
        end
        else
        begin
            m_valid_reg     <= in_valid;
            g_valid_reg     <= m_valid_reg;
            st_valid_reg[0] <= g_valid_reg;
            o_valid_reg     <= st_valid_reg[DIV_STEPS];
        end
    end

    assign num_abs  = m_num_reg[NUM_W-1] ? -m_num_reg : m_num_reg;
    assign dividend = DVD_W'(g_mag_reg) + DVD_W'(g_den_reg >> 1);

    always_ff @(posedge clk)
    begin
        m_num_reg <= NUM_W'(comp) * $signed({1'b0, r});
        m_den_reg <= den;

        g_neg_reg <= m_num_reg[NUM_W-1];
        g_mag_reg <= num_abs[MAG_W-1:0];
        g_den_reg <= m_den_reg;

        st_neg_reg[0] <= g_neg_reg;
        st_nz_reg[0]  <= (g_mag_reg != '0);
        st_den_reg[0] <= g_den_reg;
        // quotient beyond 17 bits saturates anyway
        st_ovf_reg[0] <= (dividend[DVD_W-1:R_W] >= REM_W'(g_den_reg));
        st_rem_reg[0] <= dividend[DVD_W-1:R_W];
        st_lo_reg[0]  <= dividend[R_W-1:0];
        st_q_reg[0]   <= '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [REM_W:0] trial;
        logic [REM_W:0] diff;

        assign trial = {st_rem_reg[k], st_lo_reg[k][R_W-1]};
        assign diff  = trial - (REM_W+1)'(st_den_reg[k]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                st_valid_reg[k+1] <= st_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            st_neg_reg[k+1] <= st_neg_reg[k];
            st_ovf_reg[k+1] <= st_ovf_reg[k];
            st_nz_reg[k+1]  <= st_nz_reg[k];
            st_den_reg[k+1] <= st_den_reg[k];
            st_lo_reg[k+1]  <= {st_lo_reg[k][R_W-2:0], 1'b0};
            if (trial >= (REM_W+1)'(st_den_reg[k]))
            begin
                st_rem_reg[k+1] <= diff[REM_W-1:0];
                st_q_reg[k+1]   <= {st_q_reg[k][R_W-2:0], 1'b1};
            end
            else
            begin
                st_rem_reg[k+1] <= trial[REM_W-1:0];
                st_q_reg[k+1]   <= {st_q_reg[k][R_W-2:0], 1'b0};
            end
        end
    end

    // zero divisor gives full scale by sign (zero for a zero numerator), otherwise saturate to one
    always_comb
    begin
        if (st_den_reg[DIV_STEPS] == '0)
        begin
            q_final = st_nz_reg[DIV_STEPS] ? R_W'(65536) : '0;
        end
        else if (st_ovf_reg[DIV_STEPS] || st_q_reg[DIV_STEPS] > R_W'(65536))
        begin
            q_final = R_W'(65536);
        end
        else
        begin
            q_final = st_q_reg[DIV_STEPS];
        end
        if (st_neg_reg[DIV_STEPS])
        begin
            biased = (R_W+2)'(65538) - (R_W+2)'(q_final);
        end
        else
        begin
            biased = (R_W+2)'(65538) + (R_W+2)'(q_final);
        end
    end

    // biased value never exceeds 18 bits, so the top bit is always clear
    always_ff @(posedge clk)
    begin
        o_coord_reg <= biased[TEX_W+1:2];
    end

    assign out_valid = o_valid_reg;
    assign coord     = o_coord_reg;

endmodule

[rtl/angular_map_direction_to_uv.sv]
// top level: unit direction to angular environment map coordinate
`timescale 1ns / 1ps

// channel   ports                                   transfer
// ------    -----                                   --------
// command   start, busy, dir                        start high and busy low
// result    done, result                            done high, one cycle, no hold-off
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid and cfg_ready high
//
// one direction per cycle, busy never rises; the path runs through input, square,
// 15 root steps, the cordic vectoring chain, multiply and 17-step divide
// reset clears valid bits and loads both config registers with one
// the receiver cannot stall, so nothing in the pipeline ever waits

module angular_map_direction_to_uv
    import amap_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dir_item_t            dir,
    output logic                 done,
    output tex_item_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SQ_STEPS = S_W;
    localparam int SQ_OP_W  = 2 * SQ_STEPS;
    localparam int SQ_REM_W = 20;
    localparam int ZZ_W     = 29;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic                     fwd;
    } sq_side_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic                     fwd;
        logic [DEN_W-1:0]         den;
    } cd_side_t;

    // config registers
    logic [CFG_W-1:0] tol_reg;
    logic [CFG_W-1:0] eps_reg;

    // input stage
    logic                     in_valid_reg;
    sq_side_t                 in_side_reg;
    logic signed [COMP_W-1:0] z_sat;
    logic [COMP_W:0]          z_gap;

    // square stage
    logic                     zz_valid_reg;
    sq_side_t                 zz_side_reg;
    logic [ZZ_W-1:0]          zz_reg;
    logic signed [2*COMP_W-1:0] zz_full;

    // root steps
    logic                sq_valid_reg [0:SQ_STEPS];
    sq_side_t            sq_side_reg  [0:SQ_STEPS];
    logic [SQ_OP_W-1:0]  sq_op_reg    [0:SQ_STEPS];
    logic [SQ_REM_W-1:0] sq_rem_reg   [0:SQ_STEPS];
    logic [S_W-1:0]      sq_root_reg  [0:SQ_STEPS];

    // side data alongside the cordic and the dividers
    cd_side_t cd_side_reg [0:CORDIC_LAT-1];
    logic     dv_fwd_reg  [0:DIV_LAT-1];

    logic             cd_valid;
    logic [R_W-1:0]   cd_r;
    logic             u_valid;
    logic             v_valid;
    logic [TEX_W-1:0] u_coord;
    logic [TEX_W-1:0] v_coord;

    logic      done_reg;
    tex_item_t result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // config write, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= CFG_W'(1);
            eps_reg <= CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_CENTER_TOL: tol_reg <= cfg_data;
                CFG_SINE_EPS:   eps_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // clamp z to [-one, one], then forward test against the tolerance
    always_comb
    begin
        if (dir.dir_z > 16'sd16384)
        begin
            z_sat = 16'sd16384;
        end
        else if (dir.dir_z < -16'sd16384)
        begin
            z_sat = -16'sd16384;
        end
        else
        begin
            z_sat = dir.dir_z;
        end
        z_gap = (COMP_W+1)'(17'sd16384 - (COMP_W+1)'(z_sat));
    end

    assign zz_full = in_side_reg.z * in_side_reg.z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            zz_valid_reg    <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= start && !busy;
            zz_valid_reg    <= in_valid_reg;
            sq_valid_reg[0] <= zz_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_side_reg.x   <= dir.dir_x;
        in_side_reg.y   <= dir.dir_y;
        in_side_reg.z   <= z_sat;
        in_side_reg.fwd <= (z_gap < (COMP_W+1)'(tol_reg));

        zz_side_reg <= in_side_reg;
        zz_reg      <= zz_full[ZZ_W-1:0];

        // radicand one squared minus z squared
        sq_side_reg[0] <= zz_side_reg;
        sq_op_reg[0]   <= SQ_OP_W'(ZZ_W'(1 << 28) - zz_reg);
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
    end

    // one root bit per stage, two radicand bits consumed each
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;

        assign rem_sh = {sq_rem_reg[k][SQ_REM_W-3:0], sq_op_reg[k][SQ_OP_W-1 -: 2]};
        assign trial  = SQ_REM_W'({sq_root_reg[k], 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_side_reg[k+1] <= sq_side_reg[k];
            sq_op_reg[k+1]   <= {sq_op_reg[k][SQ_OP_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                sq_rem_reg[k+1]  <= rem_sh - trial;
                sq_root_reg[k+1] <= {sq_root_reg[k][S_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg[k+1]  <= rem_sh;
                sq_root_reg[k+1] <= {sq_root_reg[k][S_W-2:0], 1'b0};
            end
        end
    end

    // angle over pi from (z, sine)
    amap_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid_reg[SQ_STEPS]),
        .z         (sq_side_reg[SQ_STEPS].z),
        .s         (sq_root_reg[SQ_STEPS]),
        .out_valid (cd_valid),
        .r         (cd_r)
    );

    // divisor is sine plus epsilon, carried beside the cordic
    always_ff @(posedge clk)
    begin
        cd_side_reg[0].x   <= sq_side_reg[SQ_STEPS].x;
        cd_side_reg[0].y   <= sq_side_reg[SQ_STEPS].y;
        cd_side_reg[0].fwd <= sq_side_reg[SQ_STEPS].fwd;
        cd_side_reg[0].den <= DEN_W'(sq_root_reg[SQ_STEPS]) + DEN_W'(eps_reg);
        for (int i = 1; i < CORDIC_LAT; i++)
        begin
            cd_side_reg[i] <= cd_side_reg[i-1];
        end
    end

    amap_div u_div_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cd_valid),
        .comp      (cd_side_reg[CORDIC_LAT-1].x),
        .r         (cd_r),
        .den       (cd_side_reg[CORDIC_LAT-1].den),
        .out_valid (u_valid),
        .coord     (u_coord)
    );

    amap_div u_div_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cd_valid),
        .comp      (cd_side_reg[CORDIC_LAT-1].y),
        .r         (cd_r),
        .den       (cd_side_reg[CORDIC_LAT-1].den),
        .out_valid (v_valid),
        .coord     (v_coord)
    );

    always_ff @(posedge clk)
    begin
        dv_fwd_reg[0] <= cd_side_reg[CORDIC_LAT-1].fwd;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            dv_fwd_reg[i] <= dv_fwd_reg[i-1];
        end
    end

    // result register, forward directions land on the map center
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= u_valid && v_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_fwd_reg[DIV_LAT-1])
        begin
            result_reg.tex_u <= TEX_W'(16384);
            result_reg.tex_v <= TEX_W'(16384);
        end
        else
        begin
            result_reg.tex_u <= u_coord;
            result_reg.tex_v <= v_coord;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
